[rtl/tun_pkg.sv]
package tun_pkg;

  localparam int CoordWidth = 16;
  localparam int NormFrac   = 15;
  localparam int NormWidth  = NormFrac + 1;

  localparam int EdgeWidth  = CoordWidth + 1;
  localparam int EdgeLimit  = 30;
  localparam int EdgeSWidth = (EdgeWidth > EdgeLimit + 1) ? EdgeLimit + 1 : EdgeWidth;
  localparam int EShWidth   = $clog2(EdgeWidth + 1);

  localparam int ProdWidth  = 2 * EdgeSWidth;
  localparam int CrossWidth = ProdWidth + 1;
  localparam int CMagWidth  = ProdWidth;
  localparam int ScaleLimit = 31;
  localparam int ShWidth    = $clog2(CMagWidth + 1);
  localparam int MagWidth   = (CMagWidth > ScaleLimit) ? ScaleLimit : CMagWidth;

  localparam int SumWidth   = 2 * MagWidth + 2;
  localparam int SqrtSteps  = MagWidth + 1;
  localparam int RootWidth  = MagWidth + 1;
  localparam int QuotWidth  = NormFrac + 1;
  localparam int DivWidth   = MagWidth + NormFrac + 1;

  typedef struct packed {
    logic signed [CoordWidth-1:0] a_x;
    logic signed [CoordWidth-1:0] a_y;
    logic signed [CoordWidth-1:0] a_z;
    logic signed [CoordWidth-1:0] b_x;
    logic signed [CoordWidth-1:0] b_y;
    logic signed [CoordWidth-1:0] b_z;
    logic signed [CoordWidth-1:0] c_x;
    logic signed [CoordWidth-1:0] c_y;
    logic signed [CoordWidth-1:0] c_z;
  } tri_t;

  typedef struct packed {
    logic signed [NormWidth-1:0] normal_x;
    logic signed [NormWidth-1:0] normal_y;
    logic signed [NormWidth-1:0] normal_z;
    logic                        degenerate;
  } normal_t;

  typedef struct packed {
    logic [2:0][MagWidth-1:0] mag;
    logic [2:0]               neg;
    logic                     degen;
  } side_t;

  typedef struct packed {
    logic [SumWidth-1:0] x;
    logic [SumWidth-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [2:0][DivWidth-1:0]  rem;
    logic [2:0][QuotWidth-1:0] quo;
    logic [RootWidth-1:0]      len;
  } div_t;

endpackage

[rtl/tun_sqrt_cell.sv]
module tun_sqrt_cell #(
  parameter int Bit = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  tun_pkg::side_t side_i,
  input  tun_pkg::sqrt_t data_i,
  output logic           valid_o,
  output tun_pkg::side_t side_o,
  output tun_pkg::sqrt_t data_o
);
  import tun_pkg::*;

  localparam logic [SumWidth:0] BitVal = (SumWidth + 1)'(1) << (2 * Bit);

  logic [SumWidth:0] trial;
  logic              take;
  sqrt_t             data_d;
  sqrt_t             data_q;
  side_t             side_q;
  logic              valid_q;

  always_comb begin
    trial = {1'b0, data_i.res} + BitVal;
    take  = {1'b0, data_i.x} >= trial;
    if (take) begin
      data_d.x   = data_i.x - trial[SumWidth-1:0];
      data_d.res = (data_i.res >> 1) + BitVal[SumWidth-1:0];
    end else begin
      data_d.x   = data_i.x;
      data_d.res = data_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign data_o  = data_q;

endmodule

[rtl/tun_div_cell.sv]
module tun_div_cell #(
  parameter int Bit = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  tun_pkg::side_t side_i,
  input  tun_pkg::div_t  data_i,
  output logic           valid_o,
  output tun_pkg::side_t side_o,
  output tun_pkg::div_t  data_o
);
  import tun_pkg::*;

  logic [DivWidth-1:0] sub;
  div_t                data_d;
  div_t                data_q;
  side_t               side_q;
  logic                valid_q;

  always_comb begin
    sub    = DivWidth'(data_i.len) << Bit;
    data_d = data_i;
    for (int i = 0; i < 3; i++) begin
      if (data_i.rem[i] >= sub) begin
        data_d.rem[i]      = data_i.rem[i] - sub;
        data_d.quo[i][Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign data_o  = data_q;

endmodule

[rtl/triangle_unit_normal_unit.sv]
// Unit normal of a triangle: one item (three Q8.8 vertices) is taken every cycle unless
// the output stalls, and one Q1.15 normal comes out per item, in order. With the default
// widths an item passes 58 register stages: eight front stages, the square-root chain
// (one cell per root bit, 32 cells), one setup stage, the divider chain (one cell per
// quotient bit, 16 cells, three lanes) and the output register. A stall while an item
// waits on the output freezes the whole pipeline and holds the input off; a stall with
// no item on the output has no effect. Degenerate triangles give a zero vector with the
// degenerate flag set.
module triangle_unit_normal_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tun_pkg::tri_t    in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tun_pkg::normal_t out_item_o
);
  import tun_pkg::*;

  localparam logic [QuotWidth-1:0] MaxPos = QuotWidth'((1 << NormFrac) - 1);

  logic en;
  logic [7:0] v_q;

  logic signed [EdgeWidth-1:0]  e_d [6];
  logic signed [EdgeWidth-1:0]  e_q [6];
  logic [EdgeWidth-1:0]         emag [6];
  logic [EdgeWidth-1:0]         eor;
  logic [EShWidth-1:0]          esh;
  logic [EdgeWidth-1:0]         esm;
  logic signed [EdgeSWidth-1:0] es_d [6];
  logic signed [EdgeSWidth-1:0] es_q [6];
  logic signed [ProdWidth-1:0]  p_d [6];
  logic signed [ProdWidth-1:0]  p_q [6];
  logic signed [CrossWidth-1:0] n_d [3];
  logic signed [CrossWidth-1:0] n_q [3];
  logic [CMagWidth-1:0]         cmag_d [3];
  logic [CMagWidth-1:0]         cmag_q [3];
  logic [CMagWidth-1:0]         cor;
  logic [2:0]                   neg_d;
  logic [2:0]                   neg_q;
  logic                         degen_d;
  logic                         degen_q;
  logic [ShWidth-1:0]           sh_d;
  logic [ShWidth-1:0]           sh_q;
  side_t                        side5_d;
  side_t                        side5_q;
  side_t                        side6_q;
  side_t                        side7_q;
  logic [SumWidth-1:0]          sq_d [3];
  logic [SumWidth-1:0]          sq_q [3];
  sqrt_t                        s7_d;
  sqrt_t                        s7_q;

  logic  sq_valid [SqrtSteps+1];
  side_t sq_side  [SqrtSteps+1];
  sqrt_t sq_data  [SqrtSteps+1];

  logic [RootWidth-1:0] root;
  logic [RootWidth-1:0] len;
  div_t                 pr_d;
  div_t                 pr_q;
  side_t                pr_side_q;
  logic                 pr_valid_q;

  logic  dv_valid [QuotWidth+1];
  side_t dv_side  [QuotWidth+1];
  div_t  dv_data  [QuotWidth+1];

  logic [2:0][NormWidth-1:0] comp;
  normal_t                   out_d;
  normal_t                   out_q;
  logic                      out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  always_comb begin
    e_d[0] = EdgeWidth'(in_item_i.b_x) - EdgeWidth'(in_item_i.a_x);
    e_d[1] = EdgeWidth'(in_item_i.b_y) - EdgeWidth'(in_item_i.a_y);
    e_d[2] = EdgeWidth'(in_item_i.b_z) - EdgeWidth'(in_item_i.a_z);
    e_d[3] = EdgeWidth'(in_item_i.c_x) - EdgeWidth'(in_item_i.a_x);
    e_d[4] = EdgeWidth'(in_item_i.c_y) - EdgeWidth'(in_item_i.a_y);
    e_d[5] = EdgeWidth'(in_item_i.c_z) - EdgeWidth'(in_item_i.a_z);
  end

  always_comb begin
    eor = '0;
    for (int i = 0; i < 6; i++) begin
      emag[i] = e_q[i][EdgeWidth-1] ? EdgeWidth'(-e_q[i]) : EdgeWidth'(e_q[i]);
      eor     = eor | emag[i];
    end
    esh = '0;
    for (int b = EdgeLimit; b < EdgeWidth; b++) begin
      if (eor[b]) begin
        esh = EShWidth'(b - EdgeLimit + 1);
      end
    end
    esm = '0;
    for (int i = 0; i < 6; i++) begin
      esm     = emag[i] >> esh;
      es_d[i] = e_q[i][EdgeWidth-1] ? -EdgeSWidth'(esm) : EdgeSWidth'(esm);
    end
  end

  always_comb begin
    p_d[0] = ProdWidth'(es_q[1]) * ProdWidth'(es_q[5]);
    p_d[1] = ProdWidth'(es_q[2]) * ProdWidth'(es_q[4]);
    p_d[2] = ProdWidth'(es_q[2]) * ProdWidth'(es_q[3]);
    p_d[3] = ProdWidth'(es_q[0]) * ProdWidth'(es_q[5]);
    p_d[4] = ProdWidth'(es_q[0]) * ProdWidth'(es_q[4]);
    p_d[5] = ProdWidth'(es_q[1]) * ProdWidth'(es_q[3]);
    for (int i = 0; i < 3; i++) begin
      n_d[i] = CrossWidth'(p_q[2*i]) - CrossWidth'(p_q[2*i+1]);
    end
  end

  always_comb begin
    cor = '0;
    for (int i = 0; i < 3; i++) begin
      neg_d[i]  = n_q[i][CrossWidth-1];
      cmag_d[i] = neg_d[i] ? CMagWidth'(-n_q[i]) : CMagWidth'(n_q[i]);
      cor       = cor | cmag_d[i];
    end
    degen_d = (cor == '0);
    sh_d    = '0;
    for (int b = ScaleLimit; b < CMagWidth; b++) begin
      if (cor[b]) begin
        sh_d = ShWidth'(b - ScaleLimit + 1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side5_d.mag[i] = MagWidth'(cmag_q[i] >> sh_q);
      sq_d[i]        = SumWidth'(side5_q.mag[i]) * SumWidth'(side5_q.mag[i]);
    end
    side5_d.neg   = neg_q;
    side5_d.degen = degen_q;
    s7_d.x        = sq_q[0] + sq_q[1] + sq_q[2];
    s7_d.res      = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[6:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q     <= e_d;
      es_q    <= es_d;
      p_q     <= p_d;
      n_q     <= n_d;
      cmag_q  <= cmag_d;
      neg_q   <= neg_d;
      degen_q <= degen_d;
      sh_q    <= sh_d;
      side5_q <= side5_d;
      sq_q    <= sq_d;
      side6_q <= side5_q;
      s7_q    <= s7_d;
      side7_q <= side6_q;
    end
  end

  assign sq_valid[0] = v_q[7];
  assign sq_side[0]  = side7_q;
  assign sq_data[0]  = s7_q;

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    tun_sqrt_cell #(
      .Bit(SqrtSteps - 1 - g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(sq_valid[g]),
      .side_i (sq_side[g]),
      .data_i (sq_data[g]),
      .valid_o(sq_valid[g+1]),
      .side_o (sq_side[g+1]),
      .data_o (sq_data[g+1])
    );
  end

  always_comb begin
    root    = sq_data[SqrtSteps].res[RootWidth-1:0];
    len     = (root == '0) ? RootWidth'(1) : root;
    pr_d.len = len;
    pr_d.quo = '0;
    for (int i = 0; i < 3; i++) begin
      pr_d.rem[i] = (DivWidth'(sq_side[SqrtSteps].mag[i]) << NormFrac) + DivWidth'(len >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_valid_q <= 1'b0;
    end else if (en) begin
      pr_valid_q <= sq_valid[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q      <= pr_d;
      pr_side_q <= sq_side[SqrtSteps];
    end
  end

  assign dv_valid[0] = pr_valid_q;
  assign dv_side[0]  = pr_side_q;
  assign dv_data[0]  = pr_q;

  for (genvar g = 0; g < QuotWidth; g++) begin : g_div
    tun_div_cell #(
      .Bit(QuotWidth - 1 - g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(dv_valid[g]),
      .side_i (dv_side[g]),
      .data_i (dv_data[g]),
      .valid_o(dv_valid[g+1]),
      .side_o (dv_side[g+1]),
      .data_o (dv_data[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_side[QuotWidth].degen) begin
        comp[i] = '0;
      end else if (dv_side[QuotWidth].neg[i]) begin
        comp[i] = -NormWidth'(dv_data[QuotWidth].quo[i]);
      end else if (dv_data[QuotWidth].quo[i] > MaxPos) begin
        comp[i] = NormWidth'(MaxPos);
      end else begin
        comp[i] = NormWidth'(dv_data[QuotWidth].quo[i]);
      end
    end
    out_d.normal_x   = comp[0];
    out_d.normal_y   = comp[1];
    out_d.normal_z   = comp[2];
    out_d.degenerate = dv_side[QuotWidth].degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid[QuotWidth];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.degenerate |->
      out_item_o.normal_x == '0 && out_item_o.normal_y == '0 && out_item_o.normal_z == '0)
    else $error("degenerate item carries a nonzero normal");

  a_nonzero_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.degenerate |->
      out_item_o.normal_x != '0 || out_item_o.normal_y != '0 || out_item_o.normal_z != '0)
    else $error("non-degenerate item gives a zero normal");

  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid[SqrtSteps] && !sq_side[SqrtSteps].degen |-> root != '0)
    else $error("square root is zero for a non-degenerate item");

endmodule

[tb/sv/triangle_unit_normal_unit_checker.sv]
`timescale 1ns / 1ps

module triangle_unit_normal_unit_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  tun_pkg::tri_t    in_item_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  tun_pkg::normal_t out_item_i,
  output int               pending_o,
  output int               errors_o
);
  import tun_pkg::*;

  normal_t normals_due[$];

  function automatic longint unsigned mag_of(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint trunc_shift(longint v, int s);
    longint unsigned m;
    m = mag_of(v) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic int fit(longint unsigned m, int lim);
    int s;
    s = 0;
    while (((m >> s) >> lim) != 0) s++;
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic normal_t unit_normal(tri_t t);
    longint e[6];
    longint n[3];
    longint unsigned m, sum, len, q, maxpos;
    int s;
    normal_t r;
    e[0] = longint'(t.b_x) - longint'(t.a_x);
    e[1] = longint'(t.b_y) - longint'(t.a_y);
    e[2] = longint'(t.b_z) - longint'(t.a_z);
    e[3] = longint'(t.c_x) - longint'(t.a_x);
    e[4] = longint'(t.c_y) - longint'(t.a_y);
    e[5] = longint'(t.c_z) - longint'(t.a_z);
    m = 0;
    for (int i = 0; i < 6; i++) if (mag_of(e[i]) > m) m = mag_of(e[i]);
    s = fit(m, 30);
    for (int i = 0; i < 6; i++) e[i] = trunc_shift(e[i], s);
    n[0] = e[1] * e[5] - e[2] * e[4];
    n[1] = e[2] * e[3] - e[0] * e[5];
    n[2] = e[0] * e[4] - e[1] * e[3];
    r = '0;
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    m = 0;
    for (int i = 0; i < 3; i++) if (mag_of(n[i]) > m) m = mag_of(n[i]);
    s = fit(m, 31);
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      n[i] = trunc_shift(n[i], s);
      sum += mag_of(n[i]) * mag_of(n[i]);
    end
    len = int_sqrt(sum);
    if (len == 0) len = 1;
    maxpos = (64'd1 << NormFrac) - 1;
    for (int i = 0; i < 3; i++) begin
      q = ((mag_of(n[i]) << NormFrac) + (len >> 1)) / len;
      if (n[i] < 0) begin
        q = -q;
      end else if (q > maxpos) begin
        q = maxpos;
      end
      case (i)
        0: r.normal_x = q[NormWidth-1:0];
        1: r.normal_y = q[NormWidth-1:0];
        default: r.normal_z = q[NormWidth-1:0];
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    normal_t want;
    if (!rst_ni) begin
      normals_due.delete();
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) normals_due = {normals_due, unit_normal(in_item_i)};
      if (out_valid_i && !out_stall_i) begin
        if (normals_due.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, out_item_i);
          errors_o <= errors_o + 1;
        end else begin
          want = normals_due.pop_front();
          if (want.normal_x !== out_item_i.normal_x ||
              want.normal_y !== out_item_i.normal_y ||
              want.normal_z !== out_item_i.normal_z ||
              want.degenerate !== out_item_i.degenerate) begin
            $display({"%0t: mismatch, expected x=%0d y=%0d z=%0d deg=%0b,",
                      " actual x=%0d y=%0d z=%0d deg=%0b"},
                     $time, want.normal_x, want.normal_y, want.normal_z, want.degenerate,
                     out_item_i.normal_x, out_item_i.normal_y, out_item_i.normal_z,
                     out_item_i.degenerate);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= normals_due.size();
    end
  end
endmodule

[tb/sv/triangle_unit_normal_unit_test.sv]
`timescale 1ns / 1ps

module triangle_unit_normal_unit_test;
  import tun_pkg::*;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  tri_t    in_item_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  normal_t out_item_o;
  int      pending;
  int      errors;
  bit      quiet = 1'b0;
  int      stall_left = 0;

  always #4 clk_i = ~clk_i;

  triangle_unit_normal_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o)
  );

  triangle_unit_normal_unit_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_i(in_stall_o), .in_item_i(in_item_i),
    .out_valid_i(out_valid_o), .out_stall_i(out_stall_i), .out_item_i(out_item_o),
    .pending_o(pending), .errors_o(errors)
  );

  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send(tri_t t);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_coord(int kind);
    case (kind)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tri_t random_tri();
    tri_t t;
    int kind, k;
    kind = $urandom_range(0, 9);
    t = '0;
    t.a_x = pick_coord($urandom_range(0, 9)); t.a_y = pick_coord($urandom_range(0, 9));
    t.a_z = pick_coord($urandom_range(0, 9)); t.b_x = pick_coord($urandom_range(0, 9));
    t.b_y = pick_coord($urandom_range(0, 9)); t.b_z = pick_coord($urandom_range(0, 9));
    t.c_x = pick_coord($urandom_range(0, 9)); t.c_y = pick_coord($urandom_range(0, 9));
    t.c_z = pick_coord($urandom_range(0, 9));
    if (kind == 0) begin
      t.c_x = t.a_x; t.c_y = t.a_y; t.c_z = t.a_z;
    end else if (kind == 1) begin
      k = $urandom_range(0, 3);
      t.b_x = 16'($urandom_range(0, 200)) - 16'd100;
      t.b_y = 16'($urandom_range(0, 200)) - 16'd100;
      t.b_z = 16'($urandom_range(0, 200)) - 16'd100;
      t.c_x = 16'(t.b_x * k); t.c_y = 16'(t.b_y * k); t.c_z = 16'(t.b_z * k);
      t.a_x = '0; t.a_y = '0; t.a_z = '0;
    end
    return t;
  endfunction

  initial begin
    tri_t t;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    t = '0;
    send(t);
    t = '0; t.b_x = 16'sd256; t.c_y = 16'sd256;
    send(t);
    t = '0; t.c_x = 16'sd256; t.b_y = 16'sd256;
    send(t);
    t = '0; t.b_y = 16'sd256; t.c_z = 16'sd256;
    send(t);
    t = '0; t.b_z = 16'sd256; t.c_y = 16'sd256;
    send(t);
    t = '0; t.b_z = 16'sd1; t.c_x = 16'sd1;
    send(t);
    t = '0; t.b_x = 16'sd1; t.c_z = 16'sd1;
    send(t);
    t = '0; t.b_x = 16'sd1; t.b_y = 16'sd1; t.c_x = 16'sd2; t.c_y = 16'sd2;
    send(t);
    t = {9{16'h8000}};
    send(t);
    t = {9{16'h7fff}};
    send(t);
    t = '0; t.a_x = 16'h8000; t.a_y = 16'h8000; t.a_z = 16'h8000;
    t.b_x = 16'h7fff; t.b_y = 16'h8000; t.b_z = 16'h8000;
    t.c_x = 16'h8000; t.c_y = 16'h7fff; t.c_z = 16'h8000;
    send(t);
    t = '0; t.a_x = 16'h7fff; t.a_y = 16'h7fff; t.a_z = 16'h7fff;
    t.b_x = 16'h8000; t.b_y = 16'h7fff; t.b_z = 16'h8000;
    t.c_x = 16'h8000; t.c_y = 16'h8000; t.c_z = 16'h7fff;
    send(t);
    t = '0; t.b_x = 16'h7fff; t.b_y = 16'h7fff; t.c_x = 16'h8000; t.c_z = 16'h7fff;
    send(t);
    t = '0; t.b_x = 16'sd3; t.b_y = 16'sd1; t.c_x = 16'sd1; t.c_y = 16'sd2; t.c_z = 16'sd5;
    send(t);
    t = {16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234,
         16'h4321, 16'h4321, 16'h4321};
    send(t);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    for (int i = 0; i < 700; i++) begin
      if (i == 600) quiet = 1'b1;
      send(random_tri());
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (errors == 0) begin
      $display("triangle_unit_normal_unit_test: done, clean");
    end else begin
      $display("triangle_unit_normal_unit_test: done, errors");
    end
    $finish;
  end

  initial begin
    #(8 * 200000);
    $display("triangle_unit_normal_unit_test: done, errors");
    $finish;
  end
endmodule
